/* rtl/ffp_pkg.sv */
// Shared constants, types and helper functions of the form field parser.
// Used by every other file of the block but the two interfaces; depends on nothing.
package ffp_pkg;

	localparam int QUEUE_DEPTH_DEF = 4;

	localparam logic [1:0] KIND_BYTE      = 2'd0;
	localparam logic [1:0] KIND_FIELD_END = 2'd1;
	localparam logic [1:0] KIND_BODY_END  = 2'd2;

	localparam logic [1:0] MODE_KEY   = 2'd0;
	localparam logic [1:0] MODE_VALUE = 2'd1;
	localparam logic [1:0] MODE_SKIP  = 2'd2;

	localparam logic [1:0] ESC_NONE = 2'd0;
	localparam logic [1:0] ESC_PCT  = 2'd1;
	localparam logic [1:0] ESC_HELD = 2'd2;

	localparam logic [7:0] CH_PCT   = 8'h25;
	localparam logic [7:0] CH_PLUS  = 8'h2B;
	localparam logic [7:0] CH_SPACE = 8'h20;
	localparam logic [7:0] CH_AMP   = 8'h26;
	localparam logic [7:0] CH_EQ    = 8'h3D;

	localparam logic [3:0] KEY_POS_MAX = 4'd15;
	localparam logic [2:0] CAND_ALL    = 3'b111;

	localparam logic [3:0] KEY_LEN [3] = '{4'd4, 4'd5, 4'd7};

	typedef struct packed {
		logic [1:0] kind;
		logic [1:0] field_id;
		logic [7:0] value_byte;
	} result_t;

	typedef struct packed {
		logic [2:0]        cnt;
		result_t [3:0]     res;
	} bundle_t;

	function automatic result_t mk_result(logic [1:0] kind, logic [1:0] fld, logic [7:0] b);
		result_t r;
		r.kind       = kind;
		r.field_id   = fld;
		r.value_byte = b;
		return r;
	endfunction

	function automatic logic [7:0] plus_map(logic [7:0] c);
		return (c == CH_PLUS) ? CH_SPACE : c;
	endfunction

	// bit 4 set when c is a hex digit, bits 3:0 its value
	function automatic logic [4:0] hex_val(logic [7:0] c);
		logic [4:0] r;
		r = 5'd0;
		if (c >= 8'h30 && c <= 8'h39)
			r = {1'b1, 4'(c - 8'h30)};
		else if (c >= 8'h61 && c <= 8'h66)
			r = {1'b1, 4'(c - 8'h57)};
		else if (c >= 8'h41 && c <= 8'h46)
			r = {1'b1, 4'(c - 8'h37)};
		return r;
	endfunction

	function automatic logic [7:0] key_char(logic [1:0] k, logic [2:0] pos);
		logic [7:0] r;
		r = 8'h00;
		unique case (k)
			2'd0: begin
				unique case (pos)
					3'd0: r = 8'h6E;
					3'd1: r = 8'h61;
					3'd2: r = 8'h6D;
					3'd3: r = 8'h65;
					default: r = 8'h00;
				endcase
			end
			2'd1: begin
				unique case (pos)
					3'd0: r = 8'h65;
					3'd1: r = 8'h6D;
					3'd2: r = 8'h61;
					3'd3: r = 8'h69;
					3'd4: r = 8'h6C;
					default: r = 8'h00;
				endcase
			end
			2'd2: begin
				unique case (pos)
					3'd0: r = 8'h6D;
					3'd1: r = 8'h65;
					3'd2: r = 8'h73;
					3'd3: r = 8'h73;
					3'd4: r = 8'h61;
					3'd5: r = 8'h67;
					3'd6: r = 8'h65;
					default: r = 8'h00;
				endcase
			end
			default: r = 8'h00;
		endcase
		return r;
	endfunction

endpackage

/* rtl/ffp_body_if.sv */
// Input channel of the form field parser: one body byte per transaction.
// Stands alone; no package needed.
interface ffp_body_if;
	logic       valid;
	logic       ready;
	logic [7:0] body_byte;
	logic       body_last;

	modport source (output valid, output body_byte, output body_last, input ready);
	modport sink (input valid, input body_byte, input body_last, output ready);
endinterface

/* rtl/ffp_result_if.sv */
// Output channel of the form field parser: one result per transaction.
// Stands alone; no package needed.
interface ffp_result_if;
	logic       valid;
	logic       ready;
	logic [1:0] result_kind;
	logic [1:0] field_id;
	logic [7:0] value_byte;
	logic       run_last;

	modport source (output valid, output result_kind, output field_id, output value_byte,
		output run_last, input ready);
	modport sink (input valid, input result_kind, input field_id, input value_byte,
		input run_last, output ready);
endinterface

/* rtl/ffp_front.sv */
// Front end: tracks token, key match and escape state and turns each body byte
// into a bundle of zero to four results. Depends on ffp_pkg.
module ffp_front (
	input  logic            clk,
	input  logic            arst_n,
	input  logic            accept,
	input  logic [7:0]      body_byte,
	input  logic            body_last,
	output logic            push,
	output ffp_pkg::bundle_t bundle
);

	logic [1:0] mode_q;
	logic [3:0] kpos_q;
	logic [2:0] cand_q;
	logic [1:0] field_q;
	logic [1:0] esc_cnt_q;
	logic [7:0] esc_chr_q;
	logic       done_q;

	logic [1:0] mode_d;
	logic [3:0] kpos_d;
	logic [2:0] cand_d;
	logic [1:0] field_d;
	logic [1:0] esc_cnt_d;
	logic [7:0] esc_chr_d;
	logic       done_d;
	logic [2:0] cnt;
	ffp_pkg::result_t [3:0] res;

	always_comb begin
		logic [4:0] h1;
		logic [4:0] h2;
		logic [7:0] dec;
		mode_d    = mode_q;
		kpos_d    = kpos_q;
		cand_d    = cand_q;
		field_d   = field_q;
		esc_cnt_d = esc_cnt_q;
		esc_chr_d = esc_chr_q;
		done_d    = done_q;
		cnt       = 3'd0;
		res       = '0;
		h1        = 5'd0;
		h2        = 5'd0;
		dec       = 8'd0;
		if (!done_q) begin
			if (body_byte != 8'd0) begin
				if (body_byte == ffp_pkg::CH_AMP) begin
					if (mode_d == ffp_pkg::MODE_VALUE) begin
						if (esc_cnt_d != ffp_pkg::ESC_NONE) begin
							res[cnt[1:0]] = ffp_pkg::mk_result(ffp_pkg::KIND_BYTE, field_d,
								ffp_pkg::CH_PCT);
							cnt = cnt + 3'd1;
						end
						if (esc_cnt_d == ffp_pkg::ESC_HELD) begin
							res[cnt[1:0]] = ffp_pkg::mk_result(ffp_pkg::KIND_BYTE, field_d,
								ffp_pkg::plus_map(esc_chr_d));
							cnt = cnt + 3'd1;
						end
						res[cnt[1:0]] = ffp_pkg::mk_result(ffp_pkg::KIND_FIELD_END, field_d, 8'd0);
						cnt = cnt + 3'd1;
					end
					mode_d    = ffp_pkg::MODE_KEY;
					kpos_d    = 4'd0;
					cand_d    = ffp_pkg::CAND_ALL;
					esc_cnt_d = ffp_pkg::ESC_NONE;
					esc_chr_d = 8'd0;
				end else if (mode_d == ffp_pkg::MODE_KEY) begin
					if (body_byte == ffp_pkg::CH_EQ) begin
						mode_d = ffp_pkg::MODE_SKIP;
						for (int k = 0; k < 3; k++) begin
							if (cand_q[k] && kpos_q == ffp_pkg::KEY_LEN[k]) begin
								mode_d    = ffp_pkg::MODE_VALUE;
								field_d   = 2'(k);
								esc_cnt_d = ffp_pkg::ESC_NONE;
							end
						end
					end else begin
						for (int k = 0; k < 3; k++) begin
							if (kpos_q >= ffp_pkg::KEY_LEN[k] ||
								ffp_pkg::key_char(2'(k), kpos_q[2:0]) != body_byte)
								cand_d[k] = 1'b0;
						end
						if (kpos_q != ffp_pkg::KEY_POS_MAX)
							kpos_d = kpos_q + 4'd1;
					end
				end else if (mode_d == ffp_pkg::MODE_VALUE) begin
					priority if (esc_cnt_d == ffp_pkg::ESC_PCT) begin
						esc_chr_d = body_byte;
						esc_cnt_d = ffp_pkg::ESC_HELD;
					end else if (esc_cnt_d == ffp_pkg::ESC_HELD) begin
						h1 = ffp_pkg::hex_val(esc_chr_q);
						h2 = ffp_pkg::hex_val(body_byte);
						if (!h1[4])
							dec = 8'd0;
						else if (!h2[4])
							dec = {4'd0, h1[3:0]};
						else
							dec = {h1[3:0], h2[3:0]};
						res[cnt[1:0]] = ffp_pkg::mk_result(ffp_pkg::KIND_BYTE, field_d, dec);
						cnt = cnt + 3'd1;
						esc_cnt_d = ffp_pkg::ESC_NONE;
					end else if (body_byte == ffp_pkg::CH_PCT) begin
						esc_cnt_d = ffp_pkg::ESC_PCT;
					end else begin
						res[cnt[1:0]] = ffp_pkg::mk_result(ffp_pkg::KIND_BYTE, field_d,
							ffp_pkg::plus_map(body_byte));
						cnt = cnt + 3'd1;
					end
				end
			end
			if (body_byte == 8'd0 || body_last) begin
				if (mode_d == ffp_pkg::MODE_VALUE) begin
					if (esc_cnt_d != ffp_pkg::ESC_NONE) begin
						res[cnt[1:0]] = ffp_pkg::mk_result(ffp_pkg::KIND_BYTE, field_d,
							ffp_pkg::CH_PCT);
						cnt = cnt + 3'd1;
					end
					if (esc_cnt_d == ffp_pkg::ESC_HELD) begin
						res[cnt[1:0]] = ffp_pkg::mk_result(ffp_pkg::KIND_BYTE, field_d,
							ffp_pkg::plus_map(esc_chr_d));
						cnt = cnt + 3'd1;
					end
					res[cnt[1:0]] = ffp_pkg::mk_result(ffp_pkg::KIND_FIELD_END, field_d, 8'd0);
					cnt = cnt + 3'd1;
				end
				mode_d    = ffp_pkg::MODE_KEY;
				kpos_d    = 4'd0;
				cand_d    = ffp_pkg::CAND_ALL;
				esc_cnt_d = ffp_pkg::ESC_NONE;
				esc_chr_d = 8'd0;
				res[cnt[1:0]] = ffp_pkg::mk_result(ffp_pkg::KIND_BODY_END, 2'd0, 8'd0);
				cnt = cnt + 3'd1;
				done_d = 1'b1;
			end
		end
	end

	assign push       = accept && (cnt != 3'd0);
	assign bundle.cnt = cnt;
	assign bundle.res = res;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mode_q    <= ffp_pkg::MODE_KEY;
			kpos_q    <= 4'd0;
			cand_q    <= ffp_pkg::CAND_ALL;
			field_q   <= 2'd0;
			esc_cnt_q <= ffp_pkg::ESC_NONE;
			esc_chr_q <= 8'd0;
			done_q    <= 1'b0;
		end else if (accept) begin
			mode_q    <= mode_d;
			kpos_q    <= kpos_d;
			cand_q    <= cand_d;
			field_q   <= field_d;
			esc_cnt_q <= esc_cnt_d;
			esc_chr_q <= esc_chr_d;
			done_q    <= done_d;
		end
	end

endmodule

/* rtl/ffp_queue.sv */
// Short queue of result bundles between the front and back ends.
// Depends on ffp_pkg for the bundle type.
module ffp_queue #(
	parameter int DEPTH = ffp_pkg::QUEUE_DEPTH_DEF
) (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             push,
	input  ffp_pkg::bundle_t wr_data,
	input  logic             pop,
	output ffp_pkg::bundle_t rd_data,
	output logic             full,
	output logic             empty
);

	localparam int PW = $clog2(DEPTH);
	localparam int CW = $clog2(DEPTH + 1);
	localparam logic [PW-1:0] PTR_LAST = PW'(DEPTH - 1);
	localparam logic [CW-1:0] CNT_FULL = CW'(DEPTH);
	localparam logic [PW-1:0] PTR_ONE  = PW'(1);
	localparam logic [CW-1:0] CNT_ONE  = CW'(1);

	ffp_pkg::bundle_t mem_q [DEPTH];
	logic [PW-1:0] wr_ptr_q;
	logic [PW-1:0] rd_ptr_q;
	logic [CW-1:0] count_q;

	assign full    = (count_q == CNT_FULL);
	assign empty   = (count_q == '0);
	assign rd_data = mem_q[rd_ptr_q];

	always_ff @(posedge clk) begin
		if (push)
			mem_q[wr_ptr_q] <= wr_data;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (push)
				wr_ptr_q <= (wr_ptr_q == PTR_LAST) ? '0 : wr_ptr_q + PTR_ONE;
			if (pop)
				rd_ptr_q <= (rd_ptr_q == PTR_LAST) ? '0 : rd_ptr_q + PTR_ONE;
			if (push && !pop)
				count_q <= count_q + CNT_ONE;
			else if (pop && !push)
				count_q <= count_q - CNT_ONE;
		end
	end

endmodule

/* rtl/ffp_back.sv */
// Back end: holds one bundle and hands out its results one per transaction.
// Depends on ffp_pkg and ffp_result_if.
module ffp_back (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             q_empty,
	input  ffp_pkg::bundle_t q_data,
	output logic             pop,
	ffp_result_if.source     result
);

	logic             busy_q;
	ffp_pkg::bundle_t bnd_q;
	logic [1:0]       idx_q;
	logic             at_end;
	ffp_pkg::result_t cur;

	assign cur    = bnd_q.res[idx_q];
	assign at_end = ({1'b0, idx_q} + 3'd1) == bnd_q.cnt;
	assign pop    = !q_empty && (!busy_q || (result.ready && at_end));

	assign result.valid       = busy_q;
	assign result.result_kind = cur.kind;
	assign result.field_id    = cur.field_id;
	assign result.value_byte  = cur.value_byte;
	assign result.run_last    = at_end;

	always_ff @(posedge clk) begin
		if (pop)
			bnd_q <= q_data;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			idx_q  <= 2'd0;
		end else if (pop) begin
			busy_q <= 1'b1;
			idx_q  <= 2'd0;
		end else if (busy_q && result.ready) begin
			if (at_end)
				busy_q <= 1'b0;
			else
				idx_q <= idx_q + 2'd1;
		end
	end

endmodule

/* rtl/form_urlencoded_field_parser.sv */
// Form body parser: takes one byte of an urlencoded body per transaction and
// emits decoded value bytes of the name, email and message fields, each field
// closed by an end-of-field result and the body by an end-of-body result.
// A byte is taken every cycle; its results (zero to four) are worked out in the
// same cycle and, if there are any, queued as one bundle, then leave one result
// per cycle while the output is ready, with the first one valid the cycle after
// the queue hands the bundle over to the back end's bundle register. Input
// stalls only while the bundle queue (QUEUE_DEPTH entries) is full, which the
// rare multi-result bytes and a stalled output side can cause. Input after the
// end of the body is taken and dropped until reset.
module form_urlencoded_field_parser #(
	parameter int QUEUE_DEPTH = ffp_pkg::QUEUE_DEPTH_DEF
) (
	input  logic         clk,
	input  logic         arst_n,
	ffp_body_if.sink     body,
	ffp_result_if.source result
);

	logic             accept;
	logic             push;
	logic             pop;
	logic             q_full;
	logic             q_empty;
	ffp_pkg::bundle_t wr_bundle;
	ffp_pkg::bundle_t rd_bundle;

	assign body.ready = !q_full;
	assign accept     = body.valid && !q_full;

	ffp_front u_front (
		.clk       (clk),
		.arst_n    (arst_n),
		.accept    (accept),
		.body_byte (body.body_byte),
		.body_last (body.body_last),
		.push      (push),
		.bundle    (wr_bundle)
	);

	ffp_queue #(
		.DEPTH (QUEUE_DEPTH)
	) u_queue (
		.clk     (clk),
		.arst_n  (arst_n),
		.push    (push),
		.wr_data (wr_bundle),
		.pop     (pop),
		.rd_data (rd_bundle),
		.full    (q_full),
		.empty   (q_empty)
	);

	ffp_back u_back (
		.clk     (clk),
		.arst_n  (arst_n),
		.q_empty (q_empty),
		.q_data  (rd_bundle),
		.pop     (pop),
		.result  (result)
	);

endmodule

/* tb/testbench.sv */
`timescale 1ns / 1ps
// Self-checking testbench of form_urlencoded_field_parser: streams one form body
// through the block and checks every result against a predictor of the decoder.
// Depends on ffp_pkg, ffp_body_if, ffp_result_if and the block itself.
module testbench;

	localparam logic [1:0] FIELD_NAME    = 2'd0;
	localparam logic [1:0] FIELD_EMAIL   = 2'd1;
	localparam logic [1:0] FIELD_MESSAGE = 2'd2;
	localparam int RANDOM_ITEMS = 360;
	localparam int IDLE_LIMIT   = 1000;
	localparam int HOLD_CYCLES  = 64;
	localparam int DRAIN_CYCLES = 16;

	typedef struct packed {
		logic [1:0] kind;
		logic [1:0] field_id;
		logic [7:0] value_byte;
		logic       run_last;
	} field_result_t;

	class form_field_board;
		field_result_t expected_q[$];
		field_result_t step_q[$];
		int unsigned   failures;
		logic [1:0]    mode;
		logic [3:0]    key_pos;
		logic [2:0]    cands;
		logic [1:0]    cur_field;
		logic [1:0]    esc_cnt;
		logic [7:0]    esc_char;
		bit            body_done;

		function new();
			failures = 0;
			cur_field = FIELD_NAME;
			body_done = 0;
			clear_token();
		endfunction

		static function string key_name(int k);
			case (k)
				FIELD_NAME: return "name";
				FIELD_EMAIL: return "email";
				default: return "message";
			endcase
		endfunction

		function int hex_digit(logic [7:0] c);
			if (c >= "0" && c <= "9") return c - "0";
			if (c >= "a" && c <= "f") return c - "a" + 10;
			if (c >= "A" && c <= "F") return c - "A" + 10;
			return -1;
		endfunction

		function logic [7:0] plain_byte(logic [7:0] c);
			return (c == ffp_pkg::CH_PLUS) ? ffp_pkg::CH_SPACE : c;
		endfunction

		function void clear_token();
			mode = ffp_pkg::MODE_KEY;
			key_pos = 4'd0;
			cands = ffp_pkg::CAND_ALL;
			esc_cnt = ffp_pkg::ESC_NONE;
			esc_char = 8'd0;
		endfunction

		function void add(logic [1:0] kind, logic [1:0] fld, logic [7:0] b);
			if (step_q.size() < 4)
				step_q.push_back('{kind, fld, b, 1'b0});
		endfunction

		// flush a pending escape literally, then close the field
		function void close_token();
			if (mode == ffp_pkg::MODE_VALUE) begin
				if (esc_cnt != ffp_pkg::ESC_NONE)
					add(ffp_pkg::KIND_BYTE, cur_field, ffp_pkg::CH_PCT);
				if (esc_cnt == ffp_pkg::ESC_HELD)
					add(ffp_pkg::KIND_BYTE, cur_field, plain_byte(esc_char));
				add(ffp_pkg::KIND_FIELD_END, cur_field, 8'd0);
			end
			clear_token();
		endfunction

		function void note_input(logic [7:0] c, logic last);
			int         k;
			int         h1;
			int         h2;
			string      kn;
			logic [7:0] v;
			if (body_done)
				return;
			step_q.delete();
			if (c != 8'd0) begin
				if (c == ffp_pkg::CH_AMP) begin
					close_token();
				end else if (mode == ffp_pkg::MODE_KEY) begin
					if (c == ffp_pkg::CH_EQ) begin
						mode = ffp_pkg::MODE_SKIP;
						for (k = 0; k < 3; k++) begin
							kn = key_name(k);
							if (cands[k] && key_pos == kn.len()) begin
								mode = ffp_pkg::MODE_VALUE;
								cur_field = 2'(k);
								esc_cnt = ffp_pkg::ESC_NONE;
							end
						end
					end else begin
						for (k = 0; k < 3; k++) begin
							kn = key_name(k);
							if (key_pos >= kn.len() || kn[key_pos] != c)
								cands[k] = 1'b0;
						end
						if (key_pos != ffp_pkg::KEY_POS_MAX)
							key_pos = key_pos + 4'd1;
					end
				end else if (mode == ffp_pkg::MODE_VALUE) begin
					if (esc_cnt == ffp_pkg::ESC_PCT) begin
						esc_char = c;
						esc_cnt = ffp_pkg::ESC_HELD;
					end else if (esc_cnt == ffp_pkg::ESC_HELD) begin
						h1 = hex_digit(esc_char);
						h2 = hex_digit(c);
						if (h1 < 0)
							v = 8'd0;
						else if (h2 < 0)
							v = 8'(h1);
						else
							v = 8'(h1 * 16 + h2);
						add(ffp_pkg::KIND_BYTE, cur_field, v);
						esc_cnt = ffp_pkg::ESC_NONE;
					end else if (c == ffp_pkg::CH_PCT) begin
						esc_cnt = ffp_pkg::ESC_PCT;
					end else begin
						add(ffp_pkg::KIND_BYTE, cur_field, plain_byte(c));
					end
				end
			end
			if (c == 8'd0 || last) begin
				close_token();
				add(ffp_pkg::KIND_BODY_END, FIELD_NAME, 8'd0);
				body_done = 1;
			end
			if (step_q.size() > 0)
				step_q[step_q.size() - 1].run_last = 1'b1;
			foreach (step_q[k])
				expected_q.push_back(step_q[k]);
		endfunction

		function void compare(string what, int want, int got);
			if (want != got) begin
				$display("%0t: %s mismatch, expected %0d, got %0d", $time, what, want, got);
				failures++;
			end
		endfunction

		function void check_result(field_result_t got);
			field_result_t want;
			if (expected_q.size() == 0) begin
				$display("%0t: unexpected result kind %0d field %0d byte 0x%02h last %0d",
					$time, got.kind, got.field_id, got.value_byte, got.run_last);
				failures++;
				return;
			end
			want = expected_q.pop_front();
			compare("result_kind", want.kind, got.kind);
			compare("field_id", want.field_id, got.field_id);
			compare("value_byte", want.value_byte, got.value_byte);
			compare("run_last", want.run_last, got.run_last);
		endfunction
	endclass

	logic clk;
	logic arst_n;

	ffp_body_if   body_ch ();
	ffp_result_if result_ch ();

	form_urlencoded_field_parser dut (
		.clk    (clk),
		.arst_n (arst_n),
		.body   (body_ch),
		.result (result_ch)
	);

	form_field_board board;
	int  items_sent;
	int  results_taken;
	int  idle_cycles;
	bit  send_steady;
	bit  take_steady;

	initial clk = 1'b0;
	always #4 clk = ~clk;

	task automatic send_byte(input logic [7:0] b, input logic last);
		int gap;
		if ($urandom_range(0, 29) == 0)
			send_steady = !send_steady;
		gap = send_steady ? 0 : $urandom_range(0, 3);
		@(negedge clk);
		if (gap > 0) begin
			body_ch.valid <= 1'b0;
			repeat (gap) @(negedge clk);
		end
		body_ch.valid <= 1'b1;
		body_ch.body_byte <= b;
		body_ch.body_last <= last;
		@(posedge clk);
		while (!body_ch.ready)
			@(posedge clk);
		board.note_input(b, last);
		items_sent++;
	endtask

	// one token of the body: mostly key=value with random content, some noise
	task automatic send_random_token();
		logic [7:0] tok[$];
		string      kn;
		string      hexchars;
		string      nonhex;
		int         shape;
		int         n;
		int         r;
		int         i;
		hexchars = "0123456789abcdefABCDEF";
		nonhex = "gxzG:/@ %+=!";
		shape = $urandom_range(0, 99);
		if (shape < 12) begin
			n = $urandom_range(1, 8);
			repeat (n) tok.push_back(8'($urandom_range(1, 255)));
		end else begin
			kn = form_field_board::key_name($urandom_range(0, 2));
			if (shape >= 75) begin
				case ($urandom_range(0, 4))
					0: kn = "";
					1: kn = kn.substr(0, kn.len() - 2);
					2: kn = {kn, "s"};
					3: kn = "Name";
					default: kn = "";
				endcase
			end
			for (i = 0; i < kn.len(); i++)
				tok.push_back(kn[i]);
			if (shape >= 75 && kn.len() == 0) begin
				n = $urandom_range(0, 3);
				repeat (n) tok.push_back(8'($urandom_range(97, 122)));
			end
			if (shape >= 20) begin
				tok.push_back(ffp_pkg::CH_EQ);
				n = $urandom_range(0, 7);
				repeat (n) begin
					r = $urandom_range(0, 99);
					if (r < 35) begin
						tok.push_back(8'($urandom_range(33, 126)));
					end else if (r < 50) begin
						tok.push_back(ffp_pkg::CH_PLUS);
					end else if (r < 70) begin
						tok.push_back(ffp_pkg::CH_PCT);
						tok.push_back(hexchars[$urandom_range(0, 21)]);
						tok.push_back(hexchars[$urandom_range(0, 21)]);
					end else if (r < 80) begin
						tok.push_back(ffp_pkg::CH_PCT);
						tok.push_back(hexchars[$urandom_range(0, 21)]);
						tok.push_back(nonhex[$urandom_range(0, nonhex.len() - 1)]);
					end else if (r < 85) begin
						tok.push_back(ffp_pkg::CH_PCT);
						tok.push_back(nonhex[$urandom_range(0, nonhex.len() - 1)]);
						tok.push_back(8'($urandom_range(1, 255)));
					end else if (r < 90) begin
						tok.push_back(ffp_pkg::CH_PCT);
					end else if (r < 95) begin
						tok.push_back(ffp_pkg::CH_EQ);
					end else begin
						tok.push_back(8'($urandom_range(1, 255)));
					end
				end
			end
		end
		tok.push_back(ffp_pkg::CH_AMP);
		if ($urandom_range(0, 9) == 0)
			tok.push_back(ffp_pkg::CH_AMP);
		foreach (tok[i])
			send_byte(tok[i], 1'b0);
	endtask

	initial begin
		string directed;
		int    i;
		int    first_random;
		arst_n = 1'b0;
		body_ch.valid = 1'b0;
		body_ch.body_byte = 8'd0;
		body_ch.body_last = 1'b0;
		board = new();
		items_sent = 0;
		send_steady = 0;
		repeat (12) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		directed = "name=%4g&email=%z%&message=%+&";
		for (i = 0; i < directed.len(); i++)
			send_byte(directed[i], 1'b0);
		first_random = items_sent;
		while (items_sent - first_random < RANDOM_ITEMS)
			send_random_token();

		// end the body, then offer bytes that must be dropped
		if ($urandom_range(0, 1))
			send_byte(8'd0, 1'($urandom_range(0, 1)));
		else
			send_byte(8'($urandom_range(1, 255)), 1'b1);
		repeat (4) send_byte(8'($urandom_range(0, 255)), 1'($urandom_range(0, 1)));
		@(negedge clk);
		body_ch.valid <= 1'b0;

		while (board.expected_q.size() != 0)
			@(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);
		if (board.failures == 0)
			$display("testbench passed");
		else
			$display("testbench failed");
		$finish;
	end

	initial begin
		int  gap;
		bit  hold_done;
		field_result_t got;
		result_ch.ready = 1'b0;
		results_taken = 0;
		hold_done = 0;
		take_steady = 0;
		@(posedge arst_n);
		forever begin
			if ($urandom_range(0, 29) == 0)
				take_steady = !take_steady;
			gap = take_steady ? 0 : $urandom_range(0, 3);
			if (results_taken >= 60 && !hold_done) begin
				gap = HOLD_CYCLES;
				hold_done = 1;
			end
			@(negedge clk);
			if (gap > 0) begin
				result_ch.ready <= 1'b0;
				repeat (gap) @(negedge clk);
			end
			result_ch.ready <= 1'b1;
			@(posedge clk);
			while (!result_ch.valid)
				@(posedge clk);
			got.kind = result_ch.result_kind;
			got.field_id = result_ch.field_id;
			got.value_byte = result_ch.value_byte;
			got.run_last = result_ch.run_last;
			board.check_result(got);
			results_taken++;
		end
	end

	always @(posedge clk) begin
		if (!arst_n || (body_ch.valid && body_ch.ready) || (result_ch.valid && result_ch.ready)) begin
			idle_cycles <= 0;
		end else if (idle_cycles >= IDLE_LIMIT) begin
			$display("%0t: no transaction for %0d cycles", $time, IDLE_LIMIT);
			$display("testbench failed");
			$finish;
		end else begin
			idle_cycles <= idle_cycles + 1;
		end
	end

endmodule
